>>> src/l3bs_pkg.sv
// shared types and constants for the l3 bus byte serializer
package l3bs_pkg;

    localparam int BIT_COUNT = 8;
    localparam int BIT_W     = $clog2(BIT_COUNT);

    // three slots per bit: clock low, data set, clock high
    localparam logic [1:0] SUB_FIRST = 2'd0;
    localparam logic [1:0] SUB_LAST  = 2'd2;

    // one pin snapshot
    typedef struct packed {
        logic mode;
        logic clock;
        logic data;
        logic last;
    } t_snap;

    // transaction handed to the sequencer
    typedef struct packed {
        logic                 start;
        logic                 is_data;
        logic [BIT_COUNT-1:0] payload;
    } t_seq_req;

    // sequencer status toward the top level
    typedef struct packed {
        logic  busy;
        t_snap snap;
    } t_seq_stat;

endpackage

>>> src/l3bs_seq.sv
// slot sequencer: holds the pin levels and walks one byte through the shift unit
module l3bs_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  l3bs_pkg::t_seq_req   i_req,
    input  logic                 i_advance,
    output l3bs_pkg::t_seq_stat  o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_PRE_HI,
        S_PRE_LO,
        S_BIT,
        S_POST_LO,
        S_POST_HI
    } t_state_e;

    t_state_e                       r_state;
    logic                           r_mode;
    logic                           r_clock;
    logic                           r_data;
    logic                           r_is_data;
    logic [l3bs_pkg::BIT_COUNT-1:0] r_shift;
    logic [l3bs_pkg::BIT_W-1:0]     r_bit;
    logic [1:0]                     r_sub;
    l3bs_pkg::t_snap                n_snap;

    always_comb begin
        n_snap.mode  = r_mode;
        n_snap.clock = r_clock;
        n_snap.data  = r_data;
        n_snap.last  = 1'b0;
        case (r_state)
            S_OPEN: begin
                n_snap.mode  = 1'b0;
                n_snap.clock = 1'b1;
                n_snap.data  = 1'b0;
            end
            S_PRE_HI: begin
                n_snap.mode = 1'b1;
            end
            S_PRE_LO: begin
                n_snap.mode = 1'b0;
            end
            S_BIT: begin
                // mode stays low for address, high for data
                n_snap.mode = r_is_data;
                case (r_sub)
                    l3bs_pkg::SUB_FIRST: begin
                        n_snap.clock = 1'b0;
                    end
                    l3bs_pkg::SUB_LAST: begin
                        n_snap.clock = 1'b1;
                        n_snap.data  = r_shift[0];
                    end
                    default: begin
                        n_snap.clock = 1'b0;
                        n_snap.data  = r_shift[0];
                    end
                endcase
            end
            S_POST_LO: begin
                n_snap.mode  = 1'b0;
                n_snap.clock = 1'b1;
            end
            S_POST_HI: begin
                n_snap.mode  = 1'b1;
                n_snap.clock = 1'b1;
                n_snap.last  = 1'b1;
            end
            default: begin
                n_snap.last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= 1'b1;
            r_clock <= 1'b1;
            r_data  <= 1'b0;
            r_bit   <= '0;
            r_sub   <= l3bs_pkg::SUB_FIRST;
        end else if (i_req.start && r_state == S_IDLE) begin
            r_state   <= i_req.is_data ? S_PRE_HI : S_OPEN;
            r_is_data <= i_req.is_data;
            r_shift   <= i_req.payload;
            r_bit     <= '0;
            r_sub     <= l3bs_pkg::SUB_FIRST;
        end else if (i_advance && r_state != S_IDLE) begin
            r_mode  <= n_snap.mode;
            r_clock <= n_snap.clock;
            r_data  <= n_snap.data;
            case (r_state)
                S_OPEN: begin
                    r_state <= S_BIT;
                end
                S_PRE_HI: begin
                    r_state <= S_PRE_LO;
                end
                S_PRE_LO: begin
                    r_state <= S_BIT;
                end
                S_BIT: begin
                    if (r_sub == l3bs_pkg::SUB_LAST) begin
                        r_sub   <= l3bs_pkg::SUB_FIRST;
                        r_shift <= r_shift >> 1;
                        if (r_bit == l3bs_pkg::BIT_W'(l3bs_pkg::BIT_COUNT - 1)) begin
                            r_state <= r_is_data ? S_POST_LO : S_POST_HI;
                        end else begin
                            r_bit <= r_bit + 1'b1;
                        end
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                S_POST_LO: begin
                    r_state <= S_POST_HI;
                end
                S_POST_HI: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.snap = n_snap;

endmodule

>>> src/l3_bus_byte_serializer.sv
// top level of the l3 bus master byte serializer
//
// input channel: i_in_valid / o_in_stall carry one transaction, a byte
// (i_payload) and its kind (i_is_data: 0 address, 1 data). output channel:
// o_out_valid / i_out_stall carry one pin snapshot per transaction (mode,
// clock, data levels), o_last_slot set on the final one of a byte.
// an address byte yields 26 snapshots, a data byte 28, bits sent lsb first.
// the slot sequencer steps the byte through a shift register, one snapshot
// per cycle while the output register is not held by a stall, and is not
// ready for a new byte until its last snapshot has moved into the output
// register. the input transaction loads the sequencer; its first snapshot
// follows into the output register once that register is free.
// a stall on the output freezes the sequencer; the output register holds
// its snapshot and the input stays stalled until the byte is done.
// synchronous active-low reset sets the sequencer's held mode and clock
// levels high, data low, and empties the output register.
module l3_bus_byte_serializer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_is_data,
    input  logic [l3bs_pkg::BIT_COUNT-1:0] i_payload,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_mode_level,
    output logic                           o_clock_level,
    output logic                           o_data_level,
    output logic                           o_last_slot
);

    l3bs_pkg::t_seq_req  seq_req;
    l3bs_pkg::t_seq_stat seq_stat;
    logic                out_take;
    logic                out_load;
    logic                r_out_valid;
    l3bs_pkg::t_snap     r_out_snap;

    assign o_in_stall      = seq_stat.busy;
    assign seq_req.start   = i_in_valid && !seq_stat.busy;
    assign seq_req.is_data = i_is_data;
    assign seq_req.payload = i_payload;

    assign out_take = r_out_valid && !i_out_stall;
    assign out_load = seq_stat.busy && (!r_out_valid || out_take);

    l3bs_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (seq_req),
        .i_advance (out_load),
        .o_stat    (seq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_snap <= seq_stat.snap;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode_level  = r_out_snap.mode;
    assign o_clock_level = r_out_snap.clock;
    assign o_data_level  = r_out_snap.data;
    assign o_last_slot   = r_out_snap.last;

    // a new byte keeps the input stalled on the following cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after input transaction");

    // the closing snapshot leaves mode and clock high
    a_last_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_slot) |-> (o_mode_level && o_clock_level))
        else $error("last snapshot with mode or clock low");

    // once the last snapshot is loaded the sequencer must be free
    a_last_frees_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && seq_stat.snap.last) |=> !o_in_stall)
        else $error("sequencer still busy after last snapshot");

    // a clock-low snapshot is never the last of a byte
    a_clock_low_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_clock_level) |-> !o_last_slot)
        else $error("last snapshot with clock low");

endmodule

>>> tb/tb_l3_bus_byte_serializer.sv
// testbench for the l3 bus byte serializer: random transfers checked against a pin-level predictor
`timescale 1ns / 100ps

module tb_l3_bus_byte_serializer;

    localparam int RUN_LIMIT     = 1_000_000;
    localparam int RANDOM_XFERS  = 450;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        ENTRY_XFER,
        ENTRY_DRAIN,
        ENTRY_HOLD
    } t_entry_kind;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    typedef struct {
        t_entry_kind                    kind;
        logic                           is_data;
        logic [l3bs_pkg::BIT_COUNT-1:0] payload;
    } t_pending;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           i_is_data     = 1'b0;
    logic [l3bs_pkg::BIT_COUNT-1:0] i_payload     = '0;
    logic                           i_out_stall   = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic                           o_mode_level;
    logic                           o_clock_level;
    logic                           o_data_level;
    logic                           o_last_slot;

    t_pending        pending_xfers[$];
    l3bs_pkg::t_snap expected_snaps[$];

    // predicted pin levels held between transfers
    logic pin_mode  = 1'b1;
    logic pin_clock = 1'b1;
    logic pin_data  = 1'b0;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_requests  = 0;

    l3_bus_byte_serializer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_is_data     (i_is_data),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mode_level  (o_mode_level),
        .o_clock_level (o_clock_level),
        .o_data_level  (o_data_level),
        .o_last_slot   (o_last_slot)
    );

    always #6 i_clk = ~i_clk;

    function void record_pins(input logic last);
        l3bs_pkg::t_snap snap;
        snap.mode  = pin_mode;
        snap.clock = pin_clock;
        snap.data  = pin_data;
        snap.last  = last;
        expected_snaps.push_back(snap);
    endfunction

    // three slots per bit: clock low, data set, clock high
    function void shift_out_bits(input logic [l3bs_pkg::BIT_COUNT-1:0] value);
        logic [l3bs_pkg::BIT_COUNT-1:0] shreg;
        shreg = value;
        for (int i = 0; i < l3bs_pkg::BIT_COUNT; i++) begin
            pin_clock = 1'b0;
            record_pins(1'b0);
            pin_data = shreg[0];
            record_pins(1'b0);
            pin_clock = 1'b1;
            record_pins(1'b0);
            shreg = shreg >> 1;
        end
    endfunction

    function void predict_pin_sequence(input logic is_data,
                                       input logic [l3bs_pkg::BIT_COUNT-1:0] value);
        if (!is_data) begin
            pin_mode  = 1'b0;
            pin_data  = 1'b0;
            pin_clock = 1'b1;
            record_pins(1'b0);
            shift_out_bits(value);
            pin_mode = 1'b1;
            record_pins(1'b1);
        end else begin
            // opening pulse shows clock and data as held from the previous transfer
            pin_mode = 1'b1;
            record_pins(1'b0);
            pin_mode = 1'b0;
            record_pins(1'b0);
            pin_mode = 1'b1;
            shift_out_bits(value);
            pin_mode = 1'b0;
            record_pins(1'b0);
            pin_mode = 1'b1;
            record_pins(1'b1);
        end
    endfunction

    task automatic queue_xfer(input logic is_data, input logic [l3bs_pkg::BIT_COUNT-1:0] value);
        t_pending entry;
        entry.kind    = ENTRY_XFER;
        entry.is_data = is_data;
        entry.payload = value;
        pending_xfers.push_back(entry);
    endtask

    task automatic queue_marker(input t_entry_kind kind);
        t_pending entry;
        entry.kind    = kind;
        entry.is_data = 1'b0;
        entry.payload = '0;
        pending_xfers.push_back(entry);
    endtask

    // sender: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic offering;
        logic drive_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_pin_sequence(i_is_data, i_payload);
                void'(pending_xfers.pop_front());
                offering = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 10);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: gap_left = 0;
                        5, 6, 7:       gap_left = $urandom_range(1, 4);
                        8:             gap_left = $urandom_range(5, 30);
                        default:       gap_left = $urandom_range(30, 80);
                    endcase
                end
            end
            if (!offering) begin
                drive_next = 1'b0;
                if (pending_xfers.size() > 0 && pending_xfers[0].kind == ENTRY_HOLD) begin
                    hold_requests <= hold_requests + 1;
                    void'(pending_xfers.pop_front());
                end else if (pending_xfers.size() > 0 && pending_xfers[0].kind == ENTRY_DRAIN) begin
                    // sender waits for every outstanding snapshot
                    if (expected_snaps.size() == 0)
                        void'(pending_xfers.pop_front());
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_xfers.size() > 0) begin
                    drive_next = 1'b1;
                end
                i_in_valid <= drive_next;
                if (drive_next) begin
                    i_is_data <= pending_xfers[0].is_data;
                    i_payload <= pending_xfers[0].payload;
                end else begin
                    i_is_data <= 1'($urandom_range(0, 1));
                    i_payload <= l3bs_pkg::BIT_COUNT'($urandom_range(0, 255));
                end
            end
        end
    end

    // receiver: checks snapshots and stalls in segments of varying style
    t_stall_style stall_style = STALL_NONE;
    int           segment_left = 0;
    int           hold_left    = 0;
    int           holds_seen   = 0;
    int           stall_phase  = 0;

    always @(posedge i_clk) begin
        l3bs_pkg::t_snap expected;
        logic            stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_snaps.size() == 0) begin
                    $error("unexpected snapshot: mode %0b clock %0b data %0b last %0b",
                           o_mode_level, o_clock_level, o_data_level, o_last_slot);
                    mismatch_count++;
                end else begin
                    expected = expected_snaps.pop_front();
                    if (o_mode_level !== expected.mode) begin
                        $error("mode_level: expected %0b, got %0b", expected.mode, o_mode_level);
                        mismatch_count++;
                    end
                    if (o_clock_level !== expected.clock) begin
                        $error("clock_level: expected %0b, got %0b",
                               expected.clock, o_clock_level);
                        mismatch_count++;
                    end
                    if (o_data_level !== expected.data) begin
                        $error("data_level: expected %0b, got %0b", expected.data, o_data_level);
                        mismatch_count++;
                    end
                    if (o_last_slot !== expected.last) begin
                        $error("last_slot: expected %0b, got %0b", expected.last, o_last_slot);
                        mismatch_count++;
                    end
                end
            end

            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (segment_left == 0) begin
                    stall_style  = t_stall_style'($urandom_range(0, 3));
                    segment_left = $urandom_range(20, 200);
                end
                segment_left--;
                stall_phase++;
                case (stall_style)
                    STALL_NONE:  stall_next = 1'b0;
                    STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                    default:     stall_next = ((stall_phase % 7) < 3);
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // data transfer straight after reset shows clock high, data low in its first slot
        queue_xfer(1'b1, 8'hFF);
        queue_xfer(1'b1, 8'h80);
        queue_xfer(1'b0, 8'h00);
        queue_xfer(1'b0, 8'hFF);
        queue_xfer(1'b1, 8'h00);
        queue_xfer(1'b0, 8'h01);
        queue_xfer(1'b0, 8'h80);
        queue_xfer(1'b1, 8'h01);
        queue_xfer(1'b1, 8'hAA);
        queue_xfer(1'b0, 8'h55);
        queue_xfer(1'b1, 8'h55);
        queue_xfer(1'b0, 8'hAA);
        queue_xfer(1'b1, 8'h7F);
        queue_xfer(1'b0, 8'hFE);
        queue_marker(ENTRY_DRAIN);

        for (int n = 0; n < RANDOM_XFERS; n++) begin
            if (n == 120 || n == 380)
                queue_marker(ENTRY_HOLD);
            if (n == 250)
                queue_marker(ENTRY_DRAIN);
            queue_xfer(1'($urandom_range(0, 1)),
                       l3bs_pkg::BIT_COUNT'($urandom_range(0, 255)));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_xfers.size() > 0 || i_in_valid || expected_snaps.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_snaps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
